>>> hw/rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LRU block cache package
// Shared widths and default sizes for the LRU block cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    localparam int TAG_W        = 48;
    localparam int OCC_W        = 9;
    localparam int CNT_W        = 32;
    localparam int DEF_CAPACITY = 256;
    localparam int DEF_BUCKETS  = 256;
    localparam int HASH_DIGIT   = 8;
    localparam int HASH_STEPS   = TAG_W / HASH_DIGIT;

endpackage

`default_nettype wire

>>> hw/rtl/lbc_ram.sv
// ----------------------------------------------------------------------------
// LRU block cache RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram
    import lbc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wa,
    input  wire logic [WIDTH-1:0] i_wd,
    input  wire logic [AW-1:0]    i_ra,
    output logic      [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

`default_nettype wire

>>> hw/rtl/lbc_hash.sv
// ----------------------------------------------------------------------------
// LRU block cache hash unit
// Reduces a block number modulo the bucket count, one byte per cycle when the
// bucket count is not a power of two, and by masking the low bits otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_hash
    import lbc_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TAG_W-1:0] i_value,
    output logic                  o_done,
    output logic      [BW-1:0]    o_bucket
);

    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic r_done;

    assign o_done = r_done;

    if (IS_POW2) begin : g_mask
        logic [TAG_W-1:0] r_val;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_val <= i_value;
            end
        end

        assign o_bucket = BW'(r_val & TAG_W'(BUCKETS - 1));
    end else begin : g_iter
        localparam int CW = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
        localparam logic [BW:0] MODV = (BW + 1)'(BUCKETS);

        logic [TAG_W-1:0] r_val;
        logic [BW-1:0]    r_rem;
        logic [BW-1:0]    n_rem;
        logic [CW-1:0]    r_cnt;
        logic             r_run;

        always_comb begin
            logic [BW:0] t;
            t = '0;
            n_rem = r_rem;
            for (int b = 0; b < HASH_DIGIT; b++) begin
                t = {n_rem, r_val[TAG_W-1-b]};
                if (t >= MODV) begin
                    t = t - MODV;
                end
                n_rem = t[BW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_run  <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_run <= 1'b1;
                    r_cnt <= '0;
                end else if (r_run) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(HASH_STEPS - 1)) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
            if (i_start) begin
                r_val <= i_value;
                r_rem <= '0;
            end else if (r_run) begin
                r_val <= r_val << HASH_DIGIT;
                r_rem <= n_rem;
            end
        end

        assign o_bucket = r_rem;
    end

endmodule

`default_nettype wire

>>> hw/rtl/lru_block_cache_lookup_top.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup
// Fully associative LRU cache of block numbers with hashed bucket chains.
//
//  Channel   Handshake                 Payload
//  input     start / busy              i_block_number
//  result    o_valid (one-cycle pulse) o_hit, o_evicted_valid, o_evicted_block,
//                                      o_occupancy, o_hit_count, o_miss_count
//
// A transaction hashes the block number and walks its bucket chain; the hash
// is iterative when the bucket count is not a power of two. A hit on the MRU
// entry skips relinking; a miss takes a free slot or evicts the LRU entry.
// Each recency link rewritten is a read and then a write of the slot RAM,
// whose single read port sets the pace. After reset a clearing pass empties
// the bucket RAM, with busy high. The result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_cache_lookup_top
    import lbc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int BUCKETS  = DEF_BUCKETS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [TAG_W-1:0] i_block_number,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_evicted_valid,
    output logic      [TAG_W-1:0] o_evicted_block,
    output logic      [OCC_W-1:0] o_occupancy,
    output logic      [CNT_W-1:0] o_hit_count,
    output logic      [CNT_W-1:0] o_miss_count
);

    localparam int PW  = $clog2(CAPACITY + 1);
    localparam int SAW = $clog2(CAPACITY);
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW  = TAG_W + 3 * PW;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    typedef enum logic [21:0] {
        S_CLR   = 22'h1 << 0,
        S_IDLE  = 22'h1 << 1,
        S_HASH  = 22'h1 << 2,
        S_BRD   = 22'h1 << 3,
        S_WALK0 = 22'h1 << 4,
        S_WALK  = 22'h1 << 5,
        S_MISS  = 22'h1 << 6,
        S_EVR   = 22'h1 << 7,
        S_UL1   = 22'h1 << 8,
        S_UL2   = 22'h1 << 9,
        S_UL3   = 22'h1 << 10,
        S_RHASH = 22'h1 << 11,
        S_RBRD  = 22'h1 << 12,
        S_RW0   = 22'h1 << 13,
        S_RWALK = 22'h1 << 14,
        S_INS   = 22'h1 << 15,
        S_INS2  = 22'h1 << 16,
        S_PUSH  = 22'h1 << 17,
        S_PB    = 22'h1 << 18,
        S_FRD   = 22'h1 << 19,
        S_FWR   = 22'h1 << 20,
        S_OUT   = 22'h1 << 21
    } t_state;

    function automatic logic [TAG_W-1:0] w_tag(input logic [WW-1:0] w);
        return w[WW-1 -: TAG_W];
    endfunction
    function automatic logic [PW-1:0] w_clink(input logic [WW-1:0] w);
        return w[3*PW-1 -: PW];
    endfunction
    function automatic logic [PW-1:0] w_next(input logic [WW-1:0] w);
        return w[2*PW-1 -: PW];
    endfunction
    function automatic logic [PW-1:0] w_prev(input logic [WW-1:0] w);
        return w[PW-1:0];
    endfunction

    t_state           r_state, n_state, r_ret, n_ret;
    logic [TAG_W-1:0] r_blk, n_blk;
    logic [BW-1:0]    r_bkt, n_bkt, r_rbkt, n_rbkt, r_clr, n_clr;
    logic [PW-1:0]    r_mru, n_mru, r_lru, n_lru, r_fill, n_fill;
    logic [PW-1:0]    r_e, n_e, r_s, n_s, r_fa, n_fa, r_fval, n_fval;
    logic             r_fnext, n_fnext;
    logic [WW-1:0]    r_word, n_word;
    logic             r_hit, n_hit, r_evv, n_evv, r_ovalid, n_ovalid;
    logic [TAG_W-1:0] r_evb, n_evb;
    logic [CNT_W-1:0] r_hits, n_hits, r_miss, n_miss;

    logic             s_we;
    logic [SAW-1:0]   s_wa, s_ra;
    logic [WW-1:0]    s_wd, s_rd;
    logic             b_we;
    logic [BW-1:0]    b_wa, b_ra;
    logic [PW-1:0]    b_wd, b_rd;
    logic             h_start, h_done;
    logic [TAG_W-1:0] h_val;
    logic [BW-1:0]    h_bkt;

    lbc_ram #(.WIDTH(WW), .DEPTH(CAPACITY), .AW(SAW)) u_slot_ram (
        .i_clk (i_clk),
        .i_we  (s_we),
        .i_wa  (s_wa),
        .i_wd  (s_wd),
        .i_ra  (s_ra),
        .o_rd  (s_rd)
    );

    lbc_ram #(.WIDTH(PW), .DEPTH(BUCKETS), .AW(BW)) u_bucket_ram (
        .i_clk (i_clk),
        .i_we  (b_we),
        .i_wa  (b_wa),
        .i_wd  (b_wd),
        .i_ra  (b_ra),
        .o_rd  (b_rd)
    );

    lbc_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (h_start),
        .i_value  (h_val),
        .o_done   (h_done),
        .o_bucket (h_bkt)
    );

    always_comb begin
        logic [PW-1:0] vp, vn, vl;
        vp = w_prev(r_word);
        vn = w_next(r_word);
        vl = w_clink(s_rd);

        n_state  = r_state;
        n_ret    = r_ret;
        n_blk    = r_blk;
        n_bkt    = r_bkt;
        n_rbkt   = r_rbkt;
        n_clr    = r_clr;
        n_mru    = r_mru;
        n_lru    = r_lru;
        n_fill   = r_fill;
        n_e      = r_e;
        n_s      = r_s;
        n_fa     = r_fa;
        n_fval   = r_fval;
        n_fnext  = r_fnext;
        n_word   = r_word;
        n_hit    = r_hit;
        n_evv    = r_evv;
        n_evb    = r_evb;
        n_hits   = r_hits;
        n_miss   = r_miss;
        n_ovalid = 1'b0;
        s_we     = 1'b0;
        s_wa     = '0;
        s_wd     = '0;
        s_ra     = '0;
        b_we     = 1'b0;
        b_wa     = '0;
        b_wd     = '0;
        b_ra     = '0;
        h_start  = 1'b0;
        h_val    = r_blk;

        unique case (r_state)
            S_CLR: begin
                b_we  = 1'b1;
                b_wa  = r_clr;
                b_wd  = NIL;
                n_clr = r_clr + 1'b1;
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_blk   = i_block_number;
                    h_start = 1'b1;
                    h_val   = i_block_number;
                    n_hit   = 1'b0;
                    n_evv   = 1'b0;
                    n_evb   = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (h_done) begin
                    n_bkt   = h_bkt;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                b_ra    = r_bkt;
                n_state = S_WALK0;
            end
            S_WALK0: begin
                if (b_rd == NIL) begin
                    n_state = S_MISS;
                end else begin
                    s_ra    = b_rd[SAW-1:0];
                    n_s     = b_rd;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_tag(s_rd) == r_blk) begin
                    n_hit  = 1'b1;
                    n_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;
                    n_e    = r_s;
                    n_word = s_rd;
                    n_state = (r_s == r_mru) ? S_OUT : S_UL1;
                end else if (vl == NIL) begin
                    n_state = S_MISS;
                end else begin
                    s_ra = vl[SAW-1:0];
                    n_s  = vl;
                end
            end
            S_MISS: begin
                n_miss = (r_miss == '1) ? r_miss : r_miss + 1'b1;
                if (r_fill < NIL) begin
                    n_e     = r_fill;
                    n_fill  = r_fill + 1'b1;
                    n_state = S_INS;
                end else begin
                    n_e     = (r_lru == NIL) ? '0 : r_lru;
                    s_ra    = (r_lru == NIL) ? '0 : r_lru[SAW-1:0];
                    n_evv   = 1'b1;
                    n_state = S_EVR;
                end
            end
            S_EVR: begin
                n_word  = s_rd;
                n_evb   = w_tag(s_rd);
                n_state = S_UL1;
            end
            S_UL1: begin
                if (vp != NIL) begin
                    n_fa    = vp;
                    n_fnext = 1'b1;
                    n_fval  = vn;
                    n_ret   = S_UL2;
                    n_state = S_FRD;
                end else begin
                    n_mru   = vn;
                    n_state = S_UL2;
                end
            end
            S_UL2: begin
                if (vn != NIL) begin
                    n_fa    = vn;
                    n_fnext = 1'b0;
                    n_fval  = vp;
                    n_ret   = S_UL3;
                    n_state = S_FRD;
                end else begin
                    n_lru   = vp;
                    n_state = S_UL3;
                end
            end
            S_UL3: begin
                if (r_hit) begin
                    n_state = S_PUSH;
                end else begin
                    h_start = 1'b1;
                    h_val   = w_tag(r_word);
                    n_state = S_RHASH;
                end
            end
            S_RHASH: begin
                if (h_done) begin
                    n_rbkt  = h_bkt;
                    n_state = S_RBRD;
                end
            end
            S_RBRD: begin
                b_ra    = r_rbkt;
                n_state = S_RW0;
            end
            S_RW0: begin
                if (b_rd == r_e) begin
                    b_we    = 1'b1;
                    b_wa    = r_rbkt;
                    b_wd    = w_clink(r_word);
                    n_state = S_INS;
                end else if (b_rd == NIL) begin
                    n_state = S_INS;
                end else begin
                    s_ra    = b_rd[SAW-1:0];
                    n_s     = b_rd;
                    n_state = S_RWALK;
                end
            end
            S_RWALK: begin
                if (vl == r_e) begin
                    s_we    = 1'b1;
                    s_wa    = r_s[SAW-1:0];
                    s_wd    = {w_tag(s_rd), w_clink(r_word), w_next(s_rd), w_prev(s_rd)};
                    n_state = S_INS;
                end else if (vl == NIL) begin
                    n_state = S_INS;
                end else begin
                    s_ra = vl[SAW-1:0];
                    n_s  = vl;
                end
            end
            S_INS: begin
                b_ra    = r_bkt;
                n_state = S_INS2;
            end
            S_INS2: begin
                n_word  = {r_blk, b_rd, NIL, NIL};
                n_state = S_PUSH;
            end
            S_PUSH: begin
                s_we  = 1'b1;
                s_wa  = r_e[SAW-1:0];
                s_wd  = {w_tag(r_word), w_clink(r_word), r_mru, NIL};
                n_mru = r_e;
                if (r_mru != NIL) begin
                    n_fa    = r_mru;
                    n_fnext = 1'b0;
                    n_fval  = r_e;
                    n_ret   = S_PB;
                    n_state = S_FRD;
                end else begin
                    n_lru   = r_e;
                    n_state = S_PB;
                end
            end
            S_PB: begin
                if (!r_hit) begin
                    b_we = 1'b1;
                    b_wa = r_bkt;
                    b_wd = r_e;
                end
                n_state = S_OUT;
            end
            S_FRD: begin
                s_ra    = r_fa[SAW-1:0];
                n_state = S_FWR;
            end
            S_FWR: begin
                s_we = 1'b1;
                s_wa = r_fa[SAW-1:0];
                if (r_fnext) begin
                    s_wd = {w_tag(s_rd), w_clink(s_rd), r_fval, w_prev(s_rd)};
                end else begin
                    s_wd = {w_tag(s_rd), w_clink(s_rd), w_next(s_rd), r_fval};
                end
                n_state = r_ret;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_mru    <= NIL;
            r_lru    <= NIL;
            r_fill   <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_mru    <= n_mru;
            r_lru    <= n_lru;
            r_fill   <= n_fill;
            r_hits   <= n_hits;
            r_miss   <= n_miss;
            r_ovalid <= n_ovalid;
        end
        r_ret   <= n_ret;
        r_blk   <= n_blk;
        r_bkt   <= n_bkt;
        r_rbkt  <= n_rbkt;
        r_e     <= n_e;
        r_s     <= n_s;
        r_fa    <= n_fa;
        r_fval  <= n_fval;
        r_fnext <= n_fnext;
        r_word  <= n_word;
        r_hit   <= n_hit;
        r_evv   <= n_evv;
        r_evb   <= n_evb;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_evv;
    assign o_evicted_block = r_evb;
    assign o_occupancy     = OCC_W'(r_fill);
    assign o_hit_count     = r_hits;
    assign o_miss_count    = r_miss;

endmodule

`default_nettype wire
